[hdl/cube_map_texel_sampler_top_macros.svh]
// assertion macros for the cube map texel sampler checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef CUBE_MAP_TEXEL_SAMPLER_TOP_MACROS_SVH
`define CUBE_MAP_TEXEL_SAMPLER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cube map sampler check failed");

// consequent must hold in the cycle after the antecedent
`define CMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cube map sampler check failed");

`endif

[hdl/cms_pkg.sv]
// shared types, widths and codes of the cube map texel sampler
// no dependencies; used by every module of the block
`default_nettype none

package cms_pkg;

    // fixed field widths
    localparam int DIR_W     = 16;
    localparam int MAG_W     = 17;   // holds 2*|component| and u + |m|
    localparam int FACE_W    = 3;
    localparam int LOAD_W    = 6;
    localparam int TEXEL_W   = 24;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 32;

    localparam int MAX_FACE_SIDE_DEF = 64;
    localparam int FACE_COUNT        = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_SIZE_RESET = 7'd64;

    // item kinds
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // face codes
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd5;
    localparam logic [FACE_W-1:0] FACE_NONE  = 3'd6;

    // one accepted input word
    typedef struct packed {
        logic                     func;
        logic signed [DIR_W-1:0]  dir_x;
        logic signed [DIR_W-1:0]  dir_y;
        logic signed [DIR_W-1:0]  dir_z;
        logic [FACE_W-1:0]        load_face;
        logic [LOAD_W-1:0]        load_column;
        logic [LOAD_W-1:0]        load_row;
        logic [TEXEL_W-1:0]       load_texel;
    } t_item;

    // sideband that rides along the divider pipeline
    typedef struct packed {
        logic                     func;
        logic                     zero;
        logic [FACE_W-1:0]        face;
        logic [FACE_W-1:0]        load_face;
        logic [LOAD_W-1:0]        load_column;
        logic [LOAD_W-1:0]        load_row;
        logic [TEXEL_W-1:0]       load_texel;
    } t_side;

    // decoded direction
    typedef struct packed {
        t_side                    side;
        logic [MAG_W-1:0]         u_off;   // u + m
        logic [MAG_W-1:0]         v_off;   // v + m
        logic [MAG_W-1:0]         den;     // 2 * m
    } t_dec;

endpackage

`default_nettype wire

[hdl/cms_dir.sv]
// direction decode stage: dominant axis, face and offset coordinates
// depends on cms_pkg
`default_nettype none

module cms_dir (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire cms_pkg::t_item i_item,
    output logic               o_valid,
    output cms_pkg::t_dec      o_dec
);

    logic                   r_valid;
    cms_pkg::t_dec          r_dec;
    cms_pkg::t_dec          n_dec;
    logic signed [17:0]     sx, sy, sz, ax, ay, az, m, u, v;

    // sign-extend and take magnitudes
    always_comb begin
        sx = 18'(i_item.dir_x);
        sy = 18'(i_item.dir_y);
        sz = 18'(i_item.dir_z);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
    end

    // axis pick in tie order z, y, x
    always_comb begin
        n_dec.side.func        = i_item.func;
        n_dec.side.zero        = (sx == 0) && (sy == 0) && (sz == 0);
        n_dec.side.load_face   = i_item.load_face;
        n_dec.side.load_column = i_item.load_column;
        n_dec.side.load_row    = i_item.load_row;
        n_dec.side.load_texel  = i_item.load_texel;
        if ((az >= ay) && (az >= ax)) begin
            m = az;
            v = -sy;
            if (sz < 0) begin
                n_dec.side.face = cms_pkg::FACE_NEG_Z;
                u = -sx;
            end else begin
                n_dec.side.face = cms_pkg::FACE_POS_Z;
                u = sx;
            end
        end else if ((ax > az) && (ax > ay)) begin
            m = ax;
            v = -sy;
            if (sx < 0) begin
                n_dec.side.face = cms_pkg::FACE_NEG_X;
                u = sz;
            end else begin
                n_dec.side.face = cms_pkg::FACE_POS_X;
                u = -sz;
            end
        end else begin
            m = ay;
            v = sz;
            if (sy < 0) begin
                n_dec.side.face = cms_pkg::FACE_NEG_Y;
                u = -sx;
            end else begin
                n_dec.side.face = cms_pkg::FACE_POS_Y;
                u = sx;
            end
        end
        // offsets lie in 0..2m, so they fit the unsigned magnitude width
        n_dec.u_off = cms_pkg::MAG_W'(u + m);
        n_dec.v_off = cms_pkg::MAG_W'(v + m);
        n_dec.den   = cms_pkg::MAG_W'(m + m);
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

`default_nettype wire

[hdl/cms_div.sv]
// scale and divide pipeline: one multiply stage, then one quotient bit per stage
// for column and row in parallel; depends on cms_pkg
`default_nettype none

module cms_div #(
    parameter int MAX_FACE_SIDE = cms_pkg::MAX_FACE_SIDE_DEF,
    localparam int SIZE_W       = $clog2(MAX_FACE_SIDE + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire logic                 i_valid,
    input  wire cms_pkg::t_dec        i_dec,
    input  wire logic [SIZE_W-1:0]    i_width,
    input  wire logic [SIZE_W-1:0]    i_height,
    output logic                      o_valid,
    output cms_pkg::t_side            o_side,
    output logic [SIZE_W-1:0]         o_q_col,
    output logic [SIZE_W-1:0]         o_q_row
);

    localparam int NW     = cms_pkg::MAG_W + SIZE_W;

    logic                   r_v    [0:SIZE_W];
    cms_pkg::t_side         r_side [0:SIZE_W];
    logic [SIZE_W-1:0]      r_q_c  [0:SIZE_W];
    logic [SIZE_W-1:0]      r_q_r  [0:SIZE_W];
    logic [NW-1:0]          r_rem_c [0:SIZE_W-1];
    logic [NW-1:0]          r_rem_r [0:SIZE_W-1];
    logic [cms_pkg::MAG_W-1:0] r_den [0:SIZE_W-1];

    logic                   n_ge_c  [0:SIZE_W-1];
    logic                   n_ge_r  [0:SIZE_W-1];
    logic [NW-1:0]          n_rem_c [0:SIZE_W-1];
    logic [NW-1:0]          n_rem_r [0:SIZE_W-1];
    logic [SIZE_W-1:0]      n_q_c   [0:SIZE_W-1];
    logic [SIZE_W-1:0]      n_q_r   [0:SIZE_W-1];

    // restoring step per stage, stage s settles quotient bit SIZE_W-1-s
    always_comb begin
        for (int s = 0; s < SIZE_W; s++) begin
            n_ge_c[s]  = r_rem_c[s] >= (NW'(r_den[s]) << (SIZE_W - 1 - s));
            n_ge_r[s]  = r_rem_r[s] >= (NW'(r_den[s]) << (SIZE_W - 1 - s));
            n_rem_c[s] = n_ge_c[s] ? r_rem_c[s] - (NW'(r_den[s]) << (SIZE_W - 1 - s))
                                   : r_rem_c[s];
            n_rem_r[s] = n_ge_r[s] ? r_rem_r[s] - (NW'(r_den[s]) << (SIZE_W - 1 - s))
                                   : r_rem_r[s];
            n_q_c[s]   = (r_q_c[s] << 1) | SIZE_W'(n_ge_c[s]);
            n_q_r[s]   = (r_q_r[s] << 1) | SIZE_W'(n_ge_r[s]);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= SIZE_W; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < SIZE_W; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    // multiply stage, quotient / sideband chain, partial remainders and divisor
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0]  <= i_dec.side;
            r_q_c[0]   <= '0;
            r_q_r[0]   <= '0;
            r_rem_c[0] <= NW'(i_width) * NW'(i_dec.u_off);
            r_rem_r[0] <= NW'(i_height) * NW'(i_dec.v_off);
            r_den[0]   <= i_dec.den;
            for (int s = 0; s < SIZE_W; s++) begin
                r_side[s+1] <= r_side[s];
                r_q_c[s+1]  <= n_q_c[s];
                r_q_r[s+1]  <= n_q_r[s];
            end
            for (int s = 0; s < SIZE_W - 1; s++) begin
                r_rem_c[s+1] <= n_rem_c[s];
                r_rem_r[s+1] <= n_rem_r[s];
                r_den[s+1]   <= r_den[s];
            end
        end
    end

    assign o_valid = r_v[SIZE_W];
    assign o_side  = r_side[SIZE_W];
    assign o_q_col = r_q_c[SIZE_W];
    assign o_q_row = r_q_r[SIZE_W];

endmodule

`default_nettype wire

[hdl/cms_mem.sv]
// texel memory with one access per cycle while the pipeline advances: a write or a registered read
// depends on cms_pkg
`default_nettype none

module cms_mem #(
    parameter int MAX_FACE_SIDE = cms_pkg::MAX_FACE_SIDE_DEF,
    localparam int SIDE_W       = (MAX_FACE_SIDE > 1) ? $clog2(MAX_FACE_SIDE) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic                  i_valid,
    input  wire cms_pkg::t_side        i_side,
    input  wire logic [SIDE_W-1:0]     i_col,
    input  wire logic [SIDE_W-1:0]     i_row,
    output logic                       o_valid,
    output logic [cms_pkg::FACE_W-1:0] o_face,
    output logic [cms_pkg::TEXEL_W-1:0] o_texel
);

    localparam int AW     = cms_pkg::FACE_W + 2 * SIDE_W;
    localparam int DEPTH  = cms_pkg::FACE_COUNT << (2 * SIDE_W);

    logic [cms_pkg::TEXEL_W-1:0] mem [0:DEPTH-1];

    logic                        r_valid;
    logic                        r_zero;
    logic [cms_pkg::FACE_W-1:0]  r_face;
    logic [cms_pkg::TEXEL_W-1:0] r_rdata;

    logic                        wr_ok;
    logic                        wr_en;
    logic                        rd_en;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;

    // write range check and addresses as {face, row, column}
    always_comb begin
        wr_ok = (int'(i_side.load_face) < cms_pkg::FACE_COUNT)
             && (int'(i_side.load_column) < MAX_FACE_SIDE)
             && (int'(i_side.load_row) < MAX_FACE_SIDE);
        wr_en   = i_adv && i_valid && (i_side.func == cms_pkg::FUNC_WRITE) && wr_ok;
        rd_en   = i_adv && i_valid && (i_side.func == cms_pkg::FUNC_SAMPLE) && !i_side.zero;
        wr_addr = {i_side.load_face, SIDE_W'(i_side.load_row), SIDE_W'(i_side.load_column)};
        rd_addr = {i_side.face, i_row, i_col};
    end

    // memory array
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_side.load_texel;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // result valid only for sample words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid && (i_side.func == cms_pkg::FUNC_SAMPLE);
        end
    end

    // face and zero-direction flag alongside the read
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_zero <= i_side.zero;
            r_face <= i_side.zero ? cms_pkg::FACE_NONE : i_side.face;
        end
    end

    assign o_valid = r_valid;
    assign o_face  = r_face;
    assign o_texel = r_zero ? '0 : r_rdata;

endmodule

`default_nettype wire

[hdl/cube_map_texel_sampler_top.sv]
// top level of the cube map texel sampler: ports, size registers, clamp, output skid
// depends on cms_pkg, cms_dir, cms_div, cms_mem
`default_nettype none

// Takes one word per clock while the skid is empty and returns one result per
// sample word, in order. A word accepted on the input passes through the input
// register, direction decode, size multiply, one stage per quotient bit of the
// column and row division, the texel memory read, then the output register.
// Write words pass through the same pipeline and update the texel memory at
// the read stage, so the single memory port does one access per cycle and
// keeps program order. A two-entry output register and skid lets the block
// keep accepting while a result waits. Texel memory has no clearing pass; an
// unwritten texel reads as whatever the memory holds.

module cube_map_texel_sampler_top #(
    parameter int MAX_FACE_SIDE = cms_pkg::MAX_FACE_SIDE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // dir_x[15:0], dir_y[31:16], dir_z[47:32], load_face[50:48],
    // load_column[56:51], load_row[62:57], load_texel[86:63], bit 87 unused
    input  wire logic [cms_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // func[0]
    input  wire logic                             i_s_axis_tuser,
    // master side
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], face_hit[26:24], zero[31:27]
    output logic [cms_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [cms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cms_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int SIDE_W = (MAX_FACE_SIDE > 1) ? $clog2(MAX_FACE_SIDE) : 1;
    localparam int SIZE_W = $clog2(MAX_FACE_SIDE + 1);
    localparam int RES_W  = cms_pkg::TEXEL_W + cms_pkg::FACE_W;

    logic [cms_pkg::CFG_W-1:0] r_face_width;
    logic [cms_pkg::CFG_W-1:0] r_face_height;
    logic [SIZE_W-1:0]         eff_w;
    logic [SIZE_W-1:0]         eff_h;

    logic                      adv;
    logic                      accept;
    logic                      r_a_valid;
    cms_pkg::t_item            r_a_item;
    cms_pkg::t_item            in_item;

    logic                      dec_valid;
    cms_pkg::t_dec             dec;

    logic                      div_valid;
    cms_pkg::t_side            div_side;
    logic [SIZE_W-1:0]         q_col;
    logic [SIZE_W-1:0]         q_row;
    logic [SIDE_W-1:0]         col;
    logic [SIDE_W-1:0]         row;

    logic                        res_valid;
    logic [cms_pkg::FACE_W-1:0]  res_face;
    logic [cms_pkg::TEXEL_W-1:0] res_texel;

    logic                      r_out_valid;
    logic                      r_skid_valid;
    logic [RES_W-1:0]          r_out_data;
    logic [RES_W-1:0]          r_skid_data;
    logic                      n_out_valid;
    logic                      n_skid_valid;
    logic                      out_take;
    logic                      load_out;
    logic                      load_skid;
    logic                      skid_to_out;

    // size registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width  <= cms_pkg::CFG_SIZE_RESET;
            r_face_height <= cms_pkg::CFG_SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cms_pkg::CFG_IDX_WIDTH:  r_face_width  <= i_cfg_data;
                cms_pkg::CFG_IDX_HEIGHT: r_face_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_face_width == '0) begin
            eff_w = SIZE_W'(1);
        end else if (int'(r_face_width) > MAX_FACE_SIDE) begin
            eff_w = SIZE_W'(MAX_FACE_SIDE);
        end else begin
            eff_w = SIZE_W'(r_face_width);
        end
        if (r_face_height == '0) begin
            eff_h = SIZE_W'(1);
        end else if (int'(r_face_height) > MAX_FACE_SIDE) begin
            eff_h = SIZE_W'(MAX_FACE_SIDE);
        end else begin
            eff_h = SIZE_W'(r_face_height);
        end
    end

    // pipeline moves whenever the skid is empty
    assign adv             = !r_skid_valid;
    assign o_s_axis_tready = adv;
    assign accept          = i_s_axis_tvalid && adv;

    // unpack the input word
    always_comb begin
        in_item.func        = i_s_axis_tuser;
        in_item.dir_x       = i_s_axis_tdata[15:0];
        in_item.dir_y       = i_s_axis_tdata[31:16];
        in_item.dir_z       = i_s_axis_tdata[47:32];
        in_item.load_face   = i_s_axis_tdata[50:48];
        in_item.load_column = i_s_axis_tdata[56:51];
        in_item.load_row    = i_s_axis_tdata[62:57];
        in_item.load_texel  = i_s_axis_tdata[86:63];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_item <= in_item;
        end
    end

    cms_dir u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_a_valid),
        .i_item  (r_a_item),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    cms_div #(
        .MAX_FACE_SIDE (MAX_FACE_SIDE)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (dec_valid),
        .i_dec    (dec),
        .i_width  (eff_w),
        .i_height (eff_h),
        .o_valid  (div_valid),
        .o_side   (div_side),
        .o_q_col  (q_col),
        .o_q_row  (q_row)
    );

    // clamp the far edge of the face to size-1
    always_comb begin
        col = (q_col >= eff_w) ? SIDE_W'(eff_w - 1'b1) : SIDE_W'(q_col);
        row = (q_row >= eff_h) ? SIDE_W'(eff_h - 1'b1) : SIDE_W'(q_row);
    end

    cms_mem #(
        .MAX_FACE_SIDE (MAX_FACE_SIDE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (div_valid),
        .i_side  (div_side),
        .i_col   (col),
        .i_row   (row),
        .o_valid (res_valid),
        .o_face  (res_face),
        .o_texel (res_texel)
    );

    // output register and skid control
    always_comb begin
        out_take     = r_out_valid && i_m_axis_tready;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        skid_to_out  = 1'b0;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (adv && res_valid) begin
            if (!r_out_valid || out_take) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            if (r_skid_valid) begin
                skid_to_out  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {res_face, res_texel};
        end else if (skid_to_out) begin
            r_out_data <= r_skid_data;
        end
        if (load_skid) begin
            r_skid_data <= {res_face, res_texel};
        end
    end

    // pack the result word
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_data[26:24], r_out_data[7:0],
                              r_out_data[15:8], r_out_data[23:16]};

endmodule

`default_nettype wire

[hdl/cms_chk.sv]
// port-level checker for the cube map texel sampler, bound to the top level
// depends on cms_pkg and cube_map_texel_sampler_top_macros.svh
`default_nettype none

`include "cube_map_texel_sampler_top_macros.svh"

module cms_chk (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_s_axis_tready,
    input  wire logic                           o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    input  wire logic [cms_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic [cms_pkg::FACE_W-1:0]  out_face;
    logic [cms_pkg::TEXEL_W-1:0] out_color;
    logic                        out_stall;

    // result fields and stall as seen on the ports
    assign out_face  = o_m_axis_tdata[26:24];
    assign out_color = o_m_axis_tdata[23:0];
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // face code never beyond the zero-direction code
    `CMS_ASSERT_NOW(a_face_code, o_m_axis_tvalid, out_face <= cms_pkg::FACE_NONE)

    // a zero direction returns black
    `CMS_ASSERT_NOW(a_zero_black, o_m_axis_tvalid && out_face == cms_pkg::FACE_NONE, out_color == '0)

    // input only backs off when a result is waiting
    `CMS_ASSERT_NOW(a_busy_backed, !o_s_axis_tready, o_m_axis_tvalid)

    // a stalled result holds
    `CMS_ASSERT_NEXT(a_stall_hold, out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule

bind cube_map_texel_sampler_top cms_chk u_cms_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
